/* hdl/fe25519_pkg.sv */
// ----------------------------------------------------------------------------
// fe25519_pkg
// Shared types and constants for the GF(2^255-19) arithmetic unit.
// ----------------------------------------------------------------------------
package fe25519_pkg;

  localparam int FE_W   = 255;
  localparam int LIMB_W = 51;
  localparam int CNT_W  = 8;

  // Field prime and the fixed exponents
  localparam logic [FE_W-1:0] P_MOD   = '1 - 255'd18;
  localparam logic [FE_W-1:0] EXP_INV = P_MOD - 255'd2;
  localparam logic [FE_W-1:0] EXP_P58 = (P_MOD - 255'd5) >> 3;
  localparam logic [FE_W-1:0] SQRT_M1 =
    255'h2b8324804fc1df0b2b4d00993dfbd7a72f431806ad2fe478c4ee1b274a0ea0b0;

  // Operation codes
  localparam logic [3:0] MODE_ADD  = 4'd0;
  localparam logic [3:0] MODE_SUB  = 4'd1;
  localparam logic [3:0] MODE_MUL  = 4'd2;
  localparam logic [3:0] MODE_SQR  = 4'd3;
  localparam logic [3:0] MODE_NEG  = 4'd4;
  localparam logic [3:0] MODE_INV  = 4'd5;
  localparam logic [3:0] MODE_P58  = 4'd6;
  localparam logic [3:0] MODE_SQRT = 4'd7;
  localparam logic [3:0] MODE_EQ   = 4'd8;
  localparam logic [3:0] MODE_SEL  = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_NEG, OP_SEL, OP_EQ, OP_CLR,
    OP_ACC_ONE, OP_RES_ACC, OP_RES_BETA
  } dp_op_t;

  typedef enum logic [2:0] {
    SRC_A, SRC_B, SRC_ACC, SRC_BETA, SRC_SQRTM1
  } src_t;

  typedef enum logic [1:0] {
    DST_ACC, DST_BETA, DST_RES
  } dst_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_start;
    src_t   xsel;
    src_t   ysel;
    dst_t   dst;
    logic   set_flag;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic chk_eq_a;
    logic chk_eq_neg;
  } dp_stat_t;

endpackage

/* hdl/fe25519_if.sv */
// ----------------------------------------------------------------------------
// fe25519_if
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
interface fe25519_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [50:0] a_limb0, a_limb1, a_limb2, a_limb3, a_limb4;
  logic [50:0] b_limb0, b_limb1, b_limb2, b_limb3, b_limb4;
  logic        cond;

  modport source (output valid, mode, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
                  b_limb0, b_limb1, b_limb2, b_limb3, b_limb4, cond, input ready);
  modport sink   (input valid, mode, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
                  b_limb0, b_limb1, b_limb2, b_limb3, b_limb4, cond, output ready);
endinterface

interface fe25519_out_if;
  logic        valid;
  logic        ready;
  logic [50:0] r_limb0, r_limb1, r_limb2, r_limb3, r_limb4;
  logic        flag;
  logic        result_zero;
  logic        result_negative;

  modport source (output valid, r_limb0, r_limb1, r_limb2, r_limb3, r_limb4, flag,
                  result_zero, result_negative, input ready);
  modport sink   (input valid, r_limb0, r_limb1, r_limb2, r_limb3, r_limb4, flag,
                  result_zero, result_negative, output ready);
endinterface

/* hdl/fe25519_mul.sv */
// ----------------------------------------------------------------------------
// fe25519_mul
// Bit-serial interleaved modular multiplier, one bit of x per cycle.
// ----------------------------------------------------------------------------
module fe25519_mul
  import fe25519_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [FE_W-1:0] x,
  input  logic [FE_W-1:0] y,
  output logic            done,
  output logic [FE_W-1:0] prod
);

  logic [FE_W-1:0]  acc_r, x_r, y_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [FE_W+1:0]  s, d1, d2;
  logic [FE_W-1:0]  acc_nxt;

  // Double, add y when the current bit is set, then fold below p
  always_comb begin
    s  = {1'b0, acc_r, 1'b0} + {2'b00, (x_r[FE_W-1] ? y_r : '0)};
    d1 = s - {2'b00, P_MOD};
    d2 = s - {1'b0, P_MOD, 1'b0};
    if (!d2[FE_W+1]) begin
      acc_nxt = d2[FE_W-1:0];
    end else if (!d1[FE_W+1]) begin
      acc_nxt = d1[FE_W-1:0];
    end else begin
      acc_nxt = s[FE_W-1:0];
    end
  end

  // Control: run FE_W steps, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FE_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      x_r   <= {x_r[FE_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* hdl/fe25519_dp.sv */
// ----------------------------------------------------------------------------
// fe25519_dp
// Operand, accumulator, beta and result registers, add/subtract/negate logic and multiplier.
// ----------------------------------------------------------------------------
module fe25519_dp
  import fe25519_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [FE_W-1:0]   a_in,
  input  logic [FE_W-1:0]   b_in,
  input  logic              cond_in,
  output dp_stat_t          stat,
  output logic [FE_W-1:0]   res,
  output logic              flag
);

  logic [FE_W-1:0] a_r, b_r, acc_r, beta_r, res_r;
  logic            flag_r, cond_r;
  dst_t            dst_r;
  logic [FE_W:0]   da, db, sum, sub;
  logic [FE_W+1:0] sum_red;
  logic [FE_W-1:0] a_can, b_can, add_res, sub_res, neg_a;
  logic [FE_W-1:0] mx, my, prod;
  logic            mdone;

  // Reduce incoming operands below p
  always_comb begin
    da    = {1'b0, a_in} - {1'b0, P_MOD};
    db    = {1'b0, b_in} - {1'b0, P_MOD};
    a_can = da[FE_W] ? a_in : da[FE_W-1:0];
    b_can = db[FE_W] ? b_in : db[FE_W-1:0];
  end

  // Modular add, subtract and negate
  always_comb begin
    sum     = {1'b0, a_r} + {1'b0, b_r};
    sum_red = {1'b0, sum} - {2'b00, P_MOD};
    add_res = sum_red[FE_W+1] ? sum[FE_W-1:0] : sum_red[FE_W-1:0];
    sub     = {1'b0, a_r} - {1'b0, b_r};
    sub_res = sub[FE_W] ? (sub[FE_W-1:0] + P_MOD) : sub[FE_W-1:0];
    neg_a   = (a_r == '0) ? '0 : (P_MOD - a_r);
  end

  function automatic logic [FE_W-1:0] pick(input src_t s, input logic [FE_W-1:0] a,
                                          input logic [FE_W-1:0] b,
                                          input logic [FE_W-1:0] acc,
                                          input logic [FE_W-1:0] beta);
    logic [FE_W-1:0] v;
    unique case (s)
      SRC_A:      v = a;
      SRC_B:      v = b;
      SRC_ACC:    v = acc;
      SRC_BETA:   v = beta;
      SRC_SQRTM1: v = SQRT_M1;
      default:    v = '0;
    endcase
    return v;
  endfunction

  assign mx = pick(cmd.xsel, a_r, b_r, acc_r, beta_r);
  assign my = pick(cmd.ysel, a_r, b_r, acc_r, beta_r);

  fe25519_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .done  (mdone),
    .prod  (prod)
  );

  // Register updates per command; multiplier writeback on done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      if (cmd.set_flag) begin
        flag_r <= 1'b1;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          a_r    <= a_can;
          b_r    <= b_can;
          cond_r <= cond_in;
          flag_r <= 1'b0;
        end
        OP_ADD:      res_r <= add_res;
        OP_SUB:      res_r <= sub_res;
        OP_NEG: begin
          b_r   <= b_r;
          res_r <= neg_a;
        end
        OP_SEL:      res_r <= cond_r ? b_r : a_r;
        OP_EQ: begin
          res_r  <= '0;
          flag_r <= (a_r == b_r);
        end
        OP_CLR:      res_r <= '0;
        OP_ACC_ONE:  acc_r <= FE_W'(1);
        OP_RES_ACC:  res_r <= acc_r;
        OP_RES_BETA: begin
          res_r  <= beta_r;
          flag_r <= 1'b1;
        end
        default: ;
      endcase
      if (cmd.mul_start) begin
        dst_r <= cmd.dst;
      end
      if (mdone) begin
        unique case (dst_r)
          DST_ACC:  acc_r  <= prod;
          DST_BETA: beta_r <= prod;
          DST_RES:  res_r  <= prod;
          default:  ;
        endcase
      end
    end
  end

  assign stat.mul_done   = mdone;
  assign stat.chk_eq_a   = (acc_r == a_r);
  assign stat.chk_eq_neg = (acc_r == neg_a);
  assign res  = res_r;
  assign flag = flag_r;

endmodule

/* hdl/fe25519_ctrl.sv */
// ----------------------------------------------------------------------------
// fe25519_ctrl
// Sequencer: dispatches each mode and walks the exponent for powers and roots.
// ----------------------------------------------------------------------------
module fe25519_ctrl
  import fe25519_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [3:0] in_mode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISP     = 9'b000000010,
    S_POW_SQ   = 9'b000000100,
    S_POW_BIT  = 9'b000001000,
    S_POW_NEXT = 9'b000010000,
    S_SQ_CHK   = 9'b000100000,
    S_SQ_TEST  = 9'b001000000,
    S_MWAIT    = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt, ret_r, ret_nxt;
  logic [3:0]       mode_r;
  logic [CNT_W-1:0] bit_r, bit_nxt;
  logic             exp_bit;

  assign exp_bit = (mode_r == MODE_INV) ? EXP_INV[bit_r] : EXP_P58[bit_r];

  // Issue a multiply; the caller parks in the wait state
  function automatic dp_cmd_t mul_cmd(input src_t x, input src_t y, input dst_t d);
    dp_cmd_t c;
    c = '{op: OP_NOP, mul_start: 1'b1, xsel: x, ysel: y, dst: d, set_flag: 1'b0};
    return c;
  endfunction

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    bit_nxt   = bit_r;
    cmd       = '{op: OP_NOP, mul_start: 1'b0, xsel: SRC_A, ysel: SRC_A,
                  dst: DST_ACC, set_flag: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        unique case (mode_r)
          MODE_ADD: cmd.op = OP_ADD;
          MODE_SUB: cmd.op = OP_SUB;
          MODE_NEG: cmd.op = OP_NEG;
          MODE_SEL: cmd.op = OP_SEL;
          MODE_EQ:  cmd.op = OP_EQ;
          MODE_MUL: begin
            cmd       = mul_cmd(SRC_A, SRC_B, DST_RES);
            ret_nxt   = S_OUT;
            state_nxt = S_MWAIT;
          end
          MODE_SQR: begin
            cmd       = mul_cmd(SRC_A, SRC_A, DST_RES);
            ret_nxt   = S_OUT;
            state_nxt = S_MWAIT;
          end
          MODE_INV, MODE_P58, MODE_SQRT: begin
            cmd.op    = OP_ACC_ONE;
            bit_nxt   = CNT_W'(FE_W - 1);
            state_nxt = S_POW_SQ;
          end
          default: cmd.op = OP_CLR;
        endcase
      end
      S_POW_SQ: begin
        cmd       = mul_cmd(SRC_ACC, SRC_ACC, DST_ACC);
        ret_nxt   = S_POW_BIT;
        state_nxt = S_MWAIT;
      end
      S_POW_BIT: begin
        if (exp_bit) begin
          cmd       = mul_cmd(SRC_ACC, SRC_A, DST_ACC);
          ret_nxt   = S_POW_NEXT;
          state_nxt = S_MWAIT;
        end else begin
          state_nxt = S_POW_NEXT;
        end
      end
      S_POW_NEXT: begin
        if (bit_r != '0) begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_POW_SQ;
        end else if (mode_r == MODE_SQRT) begin
          cmd       = mul_cmd(SRC_ACC, SRC_A, DST_BETA);
          ret_nxt   = S_SQ_CHK;
          state_nxt = S_MWAIT;
        end else begin
          cmd.op    = OP_RES_ACC;
          state_nxt = S_OUT;
        end
      end
      S_SQ_CHK: begin
        cmd       = mul_cmd(SRC_BETA, SRC_BETA, DST_ACC);
        ret_nxt   = S_SQ_TEST;
        state_nxt = S_MWAIT;
      end
      S_SQ_TEST: begin
        if (stat.chk_eq_a) begin
          cmd.op    = OP_RES_BETA;
          state_nxt = S_OUT;
        end else if (stat.chk_eq_neg) begin
          cmd          = mul_cmd(SRC_BETA, SRC_SQRTM1, DST_RES);
          cmd.set_flag = 1'b1;
          ret_nxt      = S_OUT;
          state_nxt    = S_MWAIT;
        end else begin
          cmd.op    = OP_CLR;
          state_nxt = S_OUT;
        end
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          state_nxt = ret_r;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Latch the mode with the accepted word
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mode_r <= in_mode;
    end
  end

endmodule

/* hdl/prime_field_25519_alu_top.sv */
// Add, sub, negate, select and equal use no multiply; multiply and square use one. Each
// multiply holds the shared bit-serial multiplier until it is done. Invert and power (p-5)/8
// square once per exponent bit and multiply once per set bit; square root adds two or three
// multiplies. One word in flight at a time, the next word is taken in the cycle after the
// result handshake.
// Reset (synchronous, active low) returns the sequencer to idle and drops any word.
// ----------------------------------------------------------------------------
// prime_field_25519_alu_top
// Arithmetic unit for GF(2^255-19): add, sub, mul, square, negate, invert, power (p-5)/8, roots, equal, select.
// ----------------------------------------------------------------------------
module prime_field_25519_alu_top
  import fe25519_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fe25519_in_if.sink    in_ch,
  fe25519_out_if.source out_ch
);

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [FE_W-1:0] res;
  logic            flag;

  fe25519_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fe25519_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .a_in    ({in_ch.a_limb4, in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0}),
    .b_in    ({in_ch.b_limb4, in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0}),
    .cond_in (in_ch.cond),
    .stat    (stat),
    .res     (res),
    .flag    (flag)
  );

  // Split result into limbs and derive status bits
  assign out_ch.r_limb0         = res[LIMB_W-1:0];
  assign out_ch.r_limb1         = res[2*LIMB_W-1:LIMB_W];
  assign out_ch.r_limb2         = res[3*LIMB_W-1:2*LIMB_W];
  assign out_ch.r_limb3         = res[4*LIMB_W-1:3*LIMB_W];
  assign out_ch.r_limb4         = res[5*LIMB_W-1:4*LIMB_W];
  assign out_ch.flag            = flag;
  assign out_ch.result_zero     = (res == '0);
  assign out_ch.result_negative = res[0];

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("input ready while a result word is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted before the first finished");

  a_no_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !cmd.mul_start)
    else $error("multiplier started while idle");

endmodule

/* sim/prime_field_25519_alu_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_25519_alu_top_test
// Drives operand words into the GF(2^255-19) unit through a valid/ready
// channel and compares every result word with a known answer or a wide-integer
// predictor; a directed table, then random words; both channels idle at random.
// ----------------------------------------------------------------------------
module prime_field_25519_alu_top_test
  import fe25519_pkg::*;
();

  localparam logic [3:0] MODE_FIRST_UNUSED = 4'd10;
  localparam int         RAND_WORDS        = 400;
  localparam int         HEAVY_RAND_MAX    = 2;

  typedef logic [FE_W-1:0] fe_t;

  typedef struct {
    logic [3:0] mode;
    fe_t        a;
    fe_t        b;
    logic       cond;
    logic       known;
    fe_t        r;
    logic       flag;
  } stim_row_t;

  typedef struct {
    fe_t  r;
    logic flag;
    logic zero;
    logic neg;
  } result_word_t;

  logic clk;
  logic rst_n;
  int   fail_cnt;

  fe25519_in_if  in_ch ();
  fe25519_out_if out_ch ();

  prime_field_25519_alu_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  stim_row_t    dir_rows[$];
  result_word_t pending_results[$];

  // Bring a value below 2^255 into [0, p)
  function automatic fe_t field_reduce(input fe_t x);
    return (x >= P_MOD) ? x - P_MOD : x;
  endfunction

  function automatic fe_t field_add(input fe_t x, input fe_t y);
    logic [FE_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, P_MOD}) s = s - {1'b0, P_MOD};
    return s[FE_W-1:0];
  endfunction

  function automatic fe_t field_sub(input fe_t x, input fe_t y);
    return (x >= y) ? x - y : x + (P_MOD - y);
  endfunction

  function automatic fe_t field_mul(input fe_t x, input fe_t y);
    logic [2*FE_W+1:0] prod;
    prod = (2*FE_W+2)'(x) * (2*FE_W+2)'(y);
    prod = prod % (2*FE_W+2)'(P_MOD);
    return prod[FE_W-1:0];
  endfunction

  function automatic fe_t field_pow(input fe_t x, input fe_t e);
    fe_t acc;
    acc = fe_t'(1);
    for (int i = FE_W - 1; i >= 0; i--) begin
      acc = field_mul(acc, acc);
      if (e[i]) acc = field_mul(acc, x);
    end
    return acc;
  endfunction

  // Expected result word for one operand word
  function automatic result_word_t predict_word(input logic [3:0] mode, input fe_t a_raw,
                                                input fe_t b_raw, input logic cond);
    result_word_t w;
    fe_t a, b, beta, chk;
    a = field_reduce(a_raw);
    b = field_reduce(b_raw);
    w.r    = '0;
    w.flag = 1'b0;
    case (mode)
      MODE_ADD: w.r = field_add(a, b);
      MODE_SUB: w.r = field_sub(a, b);
      MODE_MUL: w.r = field_mul(a, b);
      MODE_SQR: w.r = field_mul(a, a);
      MODE_NEG: w.r = field_sub('0, a);
      MODE_INV: w.r = field_pow(a, EXP_INV);
      MODE_P58: w.r = field_pow(a, EXP_P58);
      MODE_SQRT: begin
        beta = field_mul(field_pow(a, EXP_P58), a);
        chk  = field_mul(beta, beta);
        if (chk == a) begin
          w.r = beta;
          w.flag = 1'b1;
        end else if (chk == field_sub('0, a)) begin
          w.r = field_mul(beta, SQRT_M1);
          w.flag = 1'b1;
        end
      end
      MODE_EQ:  w.flag = (a == b);
      MODE_SEL: w.r = cond ? b : a;
      default: ;
    endcase
    w.zero = (w.r == '0);
    w.neg  = w.r[0];
    return w;
  endfunction

  function automatic fe_t rand_operand();
    fe_t v;
    logic [255:0] wide;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = fe_t'($urandom_range(0, 40));
      2: v = P_MOD - fe_t'(3) + fe_t'($urandom_range(0, 21));
      3: v = '1;
      default: begin
        for (int i = 0; i < 8; i++) wide[i*32 +: 32] = $urandom;
        v = wide[FE_W-1:0];
      end
    endcase
    return v;
  endfunction

  task automatic add_row(input logic [3:0] mode, input fe_t a, input fe_t b,
                         input logic cond, input logic known, input fe_t r,
                         input logic flag);
    stim_row_t row;
    row.mode = mode; row.a = a; row.b = b; row.cond = cond;
    row.known = known; row.r = r; row.flag = flag;
    dir_rows.push_back(row);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #40000000;
    $display("prime_field_25519_alu_top_test failed");
    $finish;
  end

  // Receiver: switch between steady ready and random stalls
  int stall_left;
  logic stall_on;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(16, 300);
      stall_on   <= $urandom_range(0, 1);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_word_t e;
    fe_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.r_limb4, out_ch.r_limb3, out_ch.r_limb2, out_ch.r_limb1, out_ch.r_limb0};
      if (pending_results.size() == 0) begin
        $error("unexpected result word r=%h", got);
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        for (int k = 0; k < 5; k++) begin
          if (got[k*LIMB_W +: LIMB_W] !== e.r[k*LIMB_W +: LIMB_W]) begin
            $error("r_limb%0d: expected %h actual %h", k, e.r[k*LIMB_W +: LIMB_W],
                   got[k*LIMB_W +: LIMB_W]);
            fail_cnt++;
          end
        end
        if (out_ch.flag !== e.flag) begin
          $error("flag: expected %b actual %b", e.flag, out_ch.flag);
          fail_cnt++;
        end
        if (out_ch.result_zero !== e.zero) begin
          $error("result_zero: expected %b actual %b", e.zero, out_ch.result_zero);
          fail_cnt++;
        end
        if (out_ch.result_negative !== e.neg) begin
          $error("result_negative: expected %b actual %b", e.neg, out_ch.result_negative);
          fail_cnt++;
        end
      end
    end
  end

  // Put one word on the input channel and hold it until accepted
  task automatic send_word(input logic [3:0] mode, input fe_t a, input fe_t b,
                           input logic cond, input logic known, input fe_t r,
                           input logic flag, inout int burst_left);
    result_word_t w;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.a_limb0 <= a[0*LIMB_W +: LIMB_W]; in_ch.b_limb0 <= b[0*LIMB_W +: LIMB_W];
    in_ch.a_limb1 <= a[1*LIMB_W +: LIMB_W]; in_ch.b_limb1 <= b[1*LIMB_W +: LIMB_W];
    in_ch.a_limb2 <= a[2*LIMB_W +: LIMB_W]; in_ch.b_limb2 <= b[2*LIMB_W +: LIMB_W];
    in_ch.a_limb3 <= a[3*LIMB_W +: LIMB_W]; in_ch.b_limb3 <= b[3*LIMB_W +: LIMB_W];
    in_ch.a_limb4 <= a[4*LIMB_W +: LIMB_W]; in_ch.b_limb4 <= b[4*LIMB_W +: LIMB_W];
    in_ch.cond    <= cond;
    if (known) begin
      w.r = r; w.flag = flag; w.zero = (r == '0); w.neg = r[0];
    end else begin
      w = predict_word(mode, a, b, cond);
    end
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(w);
    burst_left--;
  endtask

  // Main sequence
  initial begin
    logic [3:0] cheap_modes[$];
    logic [3:0] mode;
    int   burst_left;
    int   heavy_left;
    int   pick;
    fail_cnt   = 0;
    stall_left = 0;
    stall_on   = 1'b0;
    burst_left = 0;
    heavy_left = HEAVY_RAND_MAX;
    rst_n        = 1'b0;
    out_ch.ready = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_ADD;
    in_ch.cond   = 1'b0;
    {in_ch.a_limb0, in_ch.a_limb1, in_ch.a_limb2, in_ch.a_limb3, in_ch.a_limb4} = '0;
    {in_ch.b_limb0, in_ch.b_limb1, in_ch.b_limb2, in_ch.b_limb3, in_ch.b_limb4} = '0;

    // Directed table: known answers where obvious, the predictor elsewhere
    add_row(MODE_ADD, '0, '0, 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_ADD, P_MOD - 1, fe_t'(1), 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_ADD, '1, '1, 1'b0, 1'b1, fe_t'(36), 1'b0);
    add_row(MODE_SUB, '0, fe_t'(1), 1'b0, 1'b1, P_MOD - 1, 1'b0);
    add_row(MODE_SUB, P_MOD, '0, 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_MUL, P_MOD - 1, P_MOD - 1, 1'b0, 1'b1, fe_t'(1), 1'b0);
    add_row(MODE_MUL, '1, '1, 1'b0, 1'b0, '0, 1'b0);
    add_row(MODE_SQR, fe_t'(2), '0, 1'b0, 1'b1, fe_t'(4), 1'b0);
    add_row(MODE_SQR, '1, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(MODE_NEG, '0, '0, 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_NEG, fe_t'(1), '0, 1'b0, 1'b1, P_MOD - 1, 1'b0);
    // invert of zero gives zero
    add_row(MODE_INV, '0, '0, 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_INV, fe_t'(2), '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(MODE_P58, '1, '0, 1'b0, 1'b0, '0, 1'b0);
    // square roots: zero, a plain square, minus one, and a non-square
    add_row(MODE_SQRT, '0, '0, 1'b0, 1'b1, '0, 1'b1);
    add_row(MODE_SQRT, fe_t'(4), '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(MODE_SQRT, P_MOD - 1, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(MODE_SQRT, fe_t'(2), '0, 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_EQ, P_MOD, '0, 1'b0, 1'b1, '0, 1'b1);
    add_row(MODE_EQ, fe_t'(1), fe_t'(2), 1'b0, 1'b1, '0, 1'b0);
    add_row(MODE_SEL, fe_t'(5), '1, 1'b1, 1'b1, fe_t'(18), 1'b0);
    add_row(MODE_SEL, fe_t'(5), '1, 1'b0, 1'b1, fe_t'(5), 1'b0);
    add_row(MODE_FIRST_UNUSED, '1, '1, 1'b1, 1'b1, '0, 1'b0);
    add_row(4'hF, '1, '1, 1'b0, 1'b1, '0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].mode, dir_rows[i].a, dir_rows[i].b, dir_rows[i].cond,
                dir_rows[i].known, dir_rows[i].r, dir_rows[i].flag, burst_left);

    // Random words; the long exponentiations stay rare
    cheap_modes = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_SQR, MODE_NEG, MODE_EQ, MODE_SEL};
    for (int n = 0; n < RAND_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (heavy_left > 0 && pick == 0) begin
        heavy_left--;
        mode = ($urandom_range(0, 1) == 0) ? MODE_INV : MODE_SQRT;
      end else if (pick < 6) begin
        mode = MODE_FIRST_UNUSED + 4'($urandom_range(0, 5));
      end else begin
        mode = cheap_modes[$urandom_range(0, cheap_modes.size() - 1)];
      end
      send_word(mode, rand_operand(), rand_operand(), 1'($urandom_range(0, 1)),
                1'b0, '0, 1'b0, burst_left);
    end
    in_ch.valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("prime_field_25519_alu_top_test passed");
    end else begin
      $display("prime_field_25519_alu_top_test failed");
    end
    $finish;
  end

endmodule
